// ===== hw/rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: shared types and helpers of the priority tone sequencer
// Command codes, note store entry layout, store index arithmetic.
// ----------------------------------------------------------------------------
package pts_pkg;

  // default note store depth and the widest store index the design supports
  localparam int unsigned STORE_DEPTH_DEFAULT = 256;
  localparam int unsigned IDX_MAX_W           = 12;

  // command codes carried on the cmd field
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_PLAY   = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_MUTE   = 3'd3,
    CMD_UNMUTE = 3'd4,
    CMD_WRITE  = 3'd5
  } pts_cmd_t;

  // one note store entry: duration in the upper half, divisor in the lower
  typedef struct packed {
    logic [15:0] ticks;
    logic [15:0] div;
  } pts_note_t;

  // 8-bit address reduced modulo the store depth (depth of at least 16,
  // so the quotient never exceeds 15 and four conditional subtracts do)
  function automatic logic [IDX_MAX_W-1:0] wrap_addr(input logic [7:0] a,
                                                      input int unsigned depth);
    logic [16:0] r;
    logic [16:0] step;
    r = {9'd0, a};
    for (int k = 3; k >= 0; k--) begin
      step = 17'(depth << k);
      if (r >= step) begin
        r = r - step;
      end
    end
    return r[IDX_MAX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/pts_note_store.sv =====
// ----------------------------------------------------------------------------
// pts_note_store: note store memory
// One write port and one registered read port; a write to the address read
// in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module pts_note_store #(
  parameter int unsigned STORE_DEPTH = pts_pkg::STORE_DEPTH_DEFAULT,
  localparam int unsigned IDX_W      = $clog2(STORE_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  pts_pkg::pts_note_t wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output pts_pkg::pts_note_t rd_data
);

  pts_pkg::pts_note_t mem [STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read with write forwarding
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== hw/rtl/priority_tone_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// priority_tone_sequencer_core: prioritised tone list player
// Commands write notes, start, stop, mute and unmute sounds, and give ticks
// that step through the note store.
// ----------------------------------------------------------------------------
// An accepted transaction is held in the input register, its result in the
// result register. Throughput: one transaction per cycle unless results stall;
// the note store entry at the play index is read on acceptance through the
// store's registered read port. Reset (rst, synchronous): idle, unmuted, gate
// closed, divisor and terminator code zero; the note store is not cleared.
module priority_tone_sequencer_core #(
  parameter int unsigned STORE_DEPTH = pts_pkg::STORE_DEPTH_DEFAULT,
  localparam int unsigned IDX_W      = $clog2(STORE_DEPTH)
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [7:0]  address,
  input  logic [7:0]  prio,
  input  logic [15:0] note_divisor,
  input  logic [15:0] note_ticks,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        playing,
  output logic        speaker_on,
  output logic [15:0] divisor,
  output logic        divisor_loaded,
  output logic        finished,
  // terminator code register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  // input stage
  logic              a_valid;
  logic [2:0]        a_cmd;
  logic [IDX_W-1:0]  a_addr;
  logic [7:0]        a_prio;
  logic [15:0]       a_ndiv;
  logic [15:0]       a_nticks;
  logic              a_advance;
  logic              in_accept;

  // sequencer state
  logic [IDX_W-1:0]  play_index, play_index_next;
  logic [15:0]       tick_counter, tick_counter_next;
  logic              busy, busy_next;
  logic              unmuted, unmuted_next;
  logic [7:0]        active_priority, active_priority_next;
  logic              gate, gate_next;
  logic [15:0]       divisor_reg, divisor_reg_next;
  logic [15:0]       terminator_code;
  logic              loaded_next;
  logic              finished_next;

  // note store access
  pts_pkg::pts_note_t entry;
  pts_pkg::pts_note_t wr_note;
  logic              store_wr;
  logic [IDX_W-1:0]  rd_addr;

  // handshake
  assign a_advance = a_valid && (!out_valid || !out_stall);
  assign in_stall  = a_valid && !a_advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_cmd    <= cmd;
      a_addr   <= IDX_W'(pts_pkg::wrap_addr(address, STORE_DEPTH));
      a_prio   <= prio;
      a_ndiv   <= note_divisor;
      a_nticks <= note_ticks;
    end
  end

  // note store: read the entry at the play index the new transaction will see
  assign store_wr      = a_advance && (pts_pkg::pts_cmd_t'(a_cmd) == pts_pkg::CMD_WRITE);
  assign wr_note.ticks = a_nticks;
  assign wr_note.div   = a_ndiv;
  assign rd_addr       = a_advance ? play_index_next : play_index;

  pts_note_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (a_addr),
    .wr_data (wr_note),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (entry)
  );

  // command decode and state update
  always_comb begin
    play_index_next      = play_index;
    tick_counter_next    = tick_counter;
    busy_next            = busy;
    unmuted_next         = unmuted;
    active_priority_next = active_priority;
    gate_next            = gate;
    divisor_reg_next     = divisor_reg;
    loaded_next          = 1'b0;
    finished_next        = 1'b0;
    case (pts_pkg::pts_cmd_t'(a_cmd))
      pts_pkg::CMD_TICK: begin
        if (busy) begin
          if (tick_counter != 16'd0) begin
            tick_counter_next = tick_counter - 16'd1;
          end else begin
            play_index_next = (play_index == IDX_W'(STORE_DEPTH - 1)) ?
                              '0 : play_index + IDX_W'(1);
            if (entry.div == terminator_code) begin
              busy_next            = 1'b0;
              active_priority_next = 8'd0;
              gate_next            = 1'b0;
              finished_next        = 1'b1;
            end else begin
              // a zero duration wraps round to the full count
              tick_counter_next = entry.ticks - 16'd1;
              divisor_reg_next  = entry.div;
              gate_next         = unmuted;
              loaded_next       = 1'b1;
            end
          end
        end
      end
      pts_pkg::CMD_PLAY: begin
        if (!(busy && (a_prio < active_priority))) begin
          play_index_next      = a_addr;
          active_priority_next = a_prio;
          busy_next            = 1'b1;
          tick_counter_next    = 16'd0;
        end
      end
      pts_pkg::CMD_STOP: begin
        busy_next            = 1'b0;
        active_priority_next = 8'd0;
        gate_next            = 1'b0;
      end
      pts_pkg::CMD_MUTE: begin
        unmuted_next = 1'b0;
        gate_next    = 1'b0;
      end
      pts_pkg::CMD_UNMUTE: begin
        unmuted_next = 1'b1;
        if (busy) begin
          gate_next = 1'b1;
        end
      end
      default: begin
        // note writes go straight to the store; unused codes do nothing
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      play_index      <= '0;
      tick_counter    <= 16'd0;
      busy            <= 1'b0;
      unmuted         <= 1'b1;
      active_priority <= 8'd0;
      gate            <= 1'b0;
      divisor_reg     <= 16'd0;
    end else if (a_advance) begin
      play_index      <= play_index_next;
      tick_counter    <= tick_counter_next;
      busy            <= busy_next;
      unmuted         <= unmuted_next;
      active_priority <= active_priority_next;
      gate            <= gate_next;
      divisor_reg     <= divisor_reg_next;
    end
  end

  // terminator code register
  always_ff @(posedge clk) begin
    if (rst) begin
      terminator_code <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      terminator_code <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      playing        <= busy_next;
      speaker_on     <= gate_next;
      divisor        <= divisor_reg_next;
      divisor_loaded <= loaded_next;
      finished       <= finished_next;
    end
  end

  // an idle sequencer holds no priority
  assert property (@(posedge clk) disable iff (rst)
    !busy |-> (active_priority == 8'd0))
    else $error("idle sequencer holds a priority");

  // the gate is only open on a playing, unmuted sound
  assert property (@(posedge clk) disable iff (rst)
    gate |-> (busy && unmuted))
    else $error("gate open without an unmuted sound");

  // a tick either loads a note or ends the sound, never both
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(divisor_loaded && finished))
    else $error("note load and finish in one result");

  // the input side is held back only while the input stage waits
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (a_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

endmodule

// ===== test/priority_tone_sequencer_core_tb.sv =====
// ----------------------------------------------------------------------------
// priority_tone_sequencer_core_tb: self-checking bench for the tone sequencer
// A short directed script, then random tone lists and command noise in
// several idling phases, each with its own terminator code. Every result
// transaction is compared with a behavioural prediction of the sequencer.
// ----------------------------------------------------------------------------
module priority_tone_sequencer_core_tb;

  localparam int DEPTH        = pts_pkg::STORE_DEPTH_DEFAULT;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 290;

  // command codes the block ignores
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic        playing;
    logic        speaker_on;
    logic [15:0] divisor;
    logic        loaded;
    logic        finished;
  } tone_result_t;

  typedef struct packed {
    logic [2:0]   op;
    logic [7:0]   addr;
    logic [7:0]   pri;
    logic [15:0]  ndiv;
    logic [15:0]  nticks;
    logic         typed;
    tone_result_t want;
  } script_row_t;

  localparam tone_result_t RES_IDLE    = '0;
  localparam tone_result_t RES_STARTED = '{1'b1, 1'b0, 16'h0000, 1'b0, 1'b0};
  localparam tone_result_t RES_FIRST   = '{1'b1, 1'b1, 16'h1234, 1'b1, 1'b0};

  // directed script: idle behaviour, extremes, priority rules, wrap, terminator
  localparam script_row_t SCRIPT [0:26] = '{
    '{pts_pkg::CMD_TICK,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, RES_IDLE},
    '{pts_pkg::CMD_STOP,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, RES_IDLE},
    '{CMD_SPARE6,          8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, RES_IDLE},
    '{CMD_SPARE7,          8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, RES_IDLE},
    '{pts_pkg::CMD_UNMUTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, RES_IDLE},
    '{pts_pkg::CMD_WRITE,  8'hFF, 8'h00, 16'hFFFF, 16'h0001, 1'b1, RES_IDLE},
    '{pts_pkg::CMD_WRITE,  8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, RES_IDLE},
    '{pts_pkg::CMD_WRITE,  8'hFE, 8'h00, 16'h0001, 16'h0000, 1'b1, RES_IDLE},
    '{pts_pkg::CMD_WRITE,  8'hFD, 8'h00, 16'h1234, 16'h0001, 1'b1, RES_IDLE},
    '{pts_pkg::CMD_WRITE,  8'hFC, 8'h00, 16'h8000, 16'hFFFF, 1'b1, RES_IDLE},
    '{pts_pkg::CMD_PLAY,   8'hFD, 8'h00, 16'h0000, 16'h0000, 1'b1, RES_STARTED},
    '{pts_pkg::CMD_TICK,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1, RES_FIRST},
    '{pts_pkg::CMD_TICK,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_MUTE,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_TICK,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_UNMUTE, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_PLAY,   8'hFF, 8'hFF, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_PLAY,   8'h00, 8'h10, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_TICK,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_PLAY,   8'hFF, 8'hFF, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_TICK,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_TICK,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_TICK,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_MUTE,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_PLAY,   8'hFD, 8'h01, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_TICK,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE},
    '{pts_pkg::CMD_STOP,   8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, RES_IDLE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = '0;
  logic [7:0]  address = '0;
  logic [7:0]  prio = '0;
  logic [15:0] note_divisor = '0;
  logic [15:0] note_ticks = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        playing;
  logic        speaker_on;
  logic [15:0] divisor;
  logic        divisor_loaded;
  logic        finished;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  priority_tone_sequencer_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .address        (address),
    .prio           (prio),
    .note_divisor   (note_divisor),
    .note_ticks     (note_ticks),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .playing        (playing),
    .speaker_on     (speaker_on),
    .divisor        (divisor),
    .divisor_loaded (divisor_loaded),
    .finished       (finished),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted sequencer state
  pts_pkg::pts_note_t tune_mem [DEPTH];
  bit          tune_written [DEPTH];
  logic [7:0]  cur_index   = '0;
  logic [15:0] cur_count   = '0;
  logic        cur_busy    = 1'b0;
  logic        cur_unmuted = 1'b1;
  logic        cur_gate    = 1'b0;
  logic [7:0]  cur_prio    = '0;
  logic [15:0] cur_div     = '0;
  logic [15:0] end_code    = '0;

  tone_result_t reports_due [$];
  int           items_sent    = 0;
  int           errors        = 0;
  int           send_idle_pct = 0;
  int           stall_pct     = 0;
  bit           hold_req      = 1'b0;
  int           hold_left     = 0;
  int           quiet_cycles  = 0;

  // advance the predicted state by one command and return the report it gives
  function automatic tone_result_t sequencer_step(input logic [2:0] op,
                                                  input logic [7:0] addr,
                                                  input logic [7:0] pri,
                                                  input logic [15:0] ndiv,
                                                  input logic [15:0] nticks);
    tone_result_t       r;
    pts_pkg::pts_note_t n;
    r = '0;
    case (op)
      pts_pkg::CMD_TICK: begin
        if (cur_busy) begin
          if (cur_count != 16'd0) begin
            cur_count = cur_count - 16'd1;
          end else begin
            n = tune_mem[cur_index];
            cur_index = cur_index + 8'd1;
            if (n.div == end_code) begin
              cur_busy   = 1'b0;
              cur_prio   = '0;
              cur_gate   = 1'b0;
              r.finished = 1'b1;
            end else begin
              // zero duration wraps round to the longest count
              cur_count = n.ticks - 16'd1;
              cur_div   = n.div;
              cur_gate  = cur_unmuted;
              r.loaded  = 1'b1;
            end
          end
        end
      end
      pts_pkg::CMD_PLAY: begin
        if (!(cur_busy && pri < cur_prio)) begin
          cur_index = addr;
          cur_prio  = pri;
          cur_busy  = 1'b1;
          cur_count = '0;
        end
      end
      pts_pkg::CMD_STOP: begin
        cur_busy = 1'b0;
        cur_prio = '0;
        cur_gate = 1'b0;
      end
      pts_pkg::CMD_MUTE: begin
        cur_unmuted = 1'b0;
        cur_gate    = 1'b0;
      end
      pts_pkg::CMD_UNMUTE: begin
        cur_unmuted = 1'b1;
        if (cur_busy) cur_gate = 1'b1;
      end
      pts_pkg::CMD_WRITE: begin
        tune_mem[addr]     = {nticks, ndiv};
        tune_written[addr] = 1'b1;
      end
      default: ;
    endcase
    r.playing    = cur_busy;
    r.speaker_on = cur_gate;
    r.divisor    = cur_div;
    return r;
  endfunction

  // offer one command transaction; called and returns at a falling edge
  task automatic issue(input logic [2:0] op, input logic [7:0] addr, input logic [7:0] pri,
                       input logic [15:0] ndiv, input logic [15:0] nticks);
    // a tick must never fetch a note that was never written: fill it first
    if (op == pts_pkg::CMD_TICK && cur_busy && cur_count == 16'd0 &&
        !tune_written[cur_index]) begin
      op     = pts_pkg::CMD_WRITE;
      addr   = cur_index;
      ndiv   = 16'($urandom);
      nticks = 16'($urandom_range(1, 3));
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cmd          = op;
    address      = addr;
    prio         = pri;
    note_divisor = ndiv;
    note_ticks   = nticks;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reports_due.push_back(sequencer_step(op, addr, pri, ndiv, nticks));
    items_sent++;
    @(negedge clk);
  endtask

  // write a short tone list ending in a terminator, play it and tick it through
  task automatic play_tune();
    logic [7:0]  base;
    logic [15:0] d;
    logic [15:0] t;
    int          len;
    int          total;
    base  = 8'($urandom);
    len   = $urandom_range(1, 4);
    total = 1;
    for (int i = 0; i < len; i++) begin
      d = 16'($urandom);
      if (d == end_code) d = d ^ 16'h0001;
      t = ($urandom_range(0, 29) == 0) ? 16'h0000 : 16'($urandom_range(1, 3));
      // a zero-duration note runs far beyond the ticks given here
      total += (t == 16'h0000) ? 20 : int'(t);
      issue(pts_pkg::CMD_WRITE, base + 8'(i), 8'($urandom), d, t);
    end
    issue(pts_pkg::CMD_WRITE, base + 8'(len), 8'($urandom), end_code, 16'($urandom));
    issue(pts_pkg::CMD_PLAY, base, ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom),
          16'($urandom), 16'($urandom));
    total += $urandom_range(0, 2);
    for (int i = 0; i < total; i++) begin
      case ($urandom_range(0, 39))
        0: issue(pts_pkg::CMD_MUTE, 8'($urandom), 8'($urandom), 16'($urandom),
                 16'($urandom));
        1: issue(pts_pkg::CMD_UNMUTE, 8'($urandom), 8'($urandom), 16'($urandom),
                 16'($urandom));
        2: issue(pts_pkg::CMD_STOP, 8'($urandom), 8'($urandom), 16'($urandom),
                 16'($urandom));
        3: issue(pts_pkg::CMD_PLAY, 8'($urandom), 8'($urandom), 16'($urandom),
                 16'($urandom));
        default: issue(pts_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom),
                       16'($urandom));
      endcase
    end
  endtask

  // wait for the block to drain, set the terminator code, then run random traffic
  task automatic run_phase(input int s_idle, input int r_stall, input logic [15:0] code,
                           input bit squeeze);
    int stop_at;
    in_valid = 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_data  = code;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    end_code = code;
    @(negedge clk);
    cfg_valid     = 1'b0;
    send_idle_pct = s_idle;
    stall_pct     = r_stall;
    if (squeeze) hold_req = 1'b1;
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 60) begin
        play_tune();
      end else begin
        issue(3'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    in_valid = 1'b0;
  endtask

  // stimulus
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (SCRIPT[i]) begin
      issue(SCRIPT[i].op, SCRIPT[i].addr, SCRIPT[i].pri, SCRIPT[i].ndiv, SCRIPT[i].nticks);
      if (SCRIPT[i].typed) reports_due[reports_due.size() - 1] = SCRIPT[i].want;
    end
    run_phase(0, 0, 16'h0000, 1'b0);
    run_phase(49, 0, 16'hFFFF, 1'b0);
    run_phase(0, 49, 16'($urandom), 1'b0);
    run_phase(28, 28, 16'h00B6, 1'b0);
    run_phase(0, 0, 16'h0003, 1'b1);
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && reports_due.size() == 0) begin
      $display("PASS priority_tone_sequencer_core");
    end else begin
      $display("FAIL priority_tone_sequencer_core");
    end
    $finish;
  end

  // result side back-pressure, with one long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    tone_result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        $error("result transaction with no prediction waiting");
        errors++;
      end else begin
        due = reports_due.pop_front();
        check_field("playing", 16'(due.playing), 16'(playing));
        check_field("speaker_on", 16'(due.speaker_on), 16'(speaker_on));
        check_field("divisor", due.divisor, divisor);
        check_field("divisor_loaded", 16'(due.loaded), 16'(divisor_loaded));
        check_field("finished", 16'(due.finished), 16'(finished));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL priority_tone_sequencer_core");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/pts_pkg.sv
hw/rtl/pts_note_store.sv
hw/rtl/priority_tone_sequencer_core.sv
test/priority_tone_sequencer_core_tb.sv
